### hdl/bcmm_pkg.sv
// Shared types, constants and helper functions for the bit-crusher mixer.
// Used by bcmm_coef_mac and bitcrush_multimode_mix_top; no dependencies.
`timescale 1ns / 1ps

package bcmm_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 4;
  localparam int AMOUNT_W   = 7;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  // Filter state width (signed, fixed point)
  localparam int STATE_W = 40;

  // Mix datapath: accumulator, magnitude and divider sizes
  localparam int MIX_W     = 24;
  localparam int MAG_W     = 22;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = 5;
  localparam int REM_W     = 7;
  localparam logic [REM_W:0] MIX_DIV = 8'd127;

  // Filter cut-off coefficient, 32 fractional bits
  localparam longint COEF_C_Q32 = 64'sd76422811;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 1'b0,
    REG_AMOUNT = 1'b1
  } cfg_reg_t;

  // Effect select codes
  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS    = 4'd0,
    MODE_MASK_100F = 4'd1,
    MODE_MASK_0FFF = 4'd2,
    MODE_SHL14     = 4'd3,
    MODE_SHL1      = 4'd4,
    MODE_SHL2      = 4'd5,
    MODE_SHL3      = 4'd6,
    MODE_SHL5      = 4'd7,
    MODE_SHL6      = 4'd8,
    MODE_INVERT    = 4'd9,
    MODE_MASK_F000 = 4'd10,
    MODE_MASK_E7FF = 4'd11,
    MODE_MASK_0087 = 4'd12,
    MODE_MASK_F7FF = 4'd13,
    MODE_ZERO      = 4'd14,
    MODE_LOWPASS   = 4'd15
  } mode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BAND_GO,
    ST_BAND,
    ST_OUT_GO,
    ST_OUT,
    ST_WET,
    ST_MUL,
    ST_ABS,
    ST_DIV,
    ST_DONE
  } fsm_t;

  // Cut-off coefficient c, rounded to frac fractional bits
  function automatic longint coef_c(input int frac);
    return (COEF_C_Q32 + (longint'(1) << (31 - frac))) >>> (32 - frac);
  endfunction

  // Damping coefficient r*c = c/16, rounded to frac fractional bits
  function automatic longint coef_rc(input int frac);
    return (COEF_C_Q32 + (longint'(1) << (35 - frac))) >>> (36 - frac);
  endfunction

  // Width of the filter accumulator: 41-bit operand times c, plus one guard bit
  function automatic int acc_width(input int frac);
    return STATE_W + 2 + $clog2(coef_c(frac) + 1);
  endfunction

  // Wet sample for the mask, shift, invert and zero modes
  function automatic logic signed [SAMPLE_W-1:0] crush_wet(
    input logic [SAMPLE_W-1:0] s,
    input mode_t               m
  );
    logic [SAMPLE_W-1:0] w;
    case (m)
      MODE_MASK_100F: w = s & 16'h100F;
      MODE_MASK_0FFF: w = s & 16'h0FFF;
      MODE_SHL14:     w = s << 14;
      MODE_SHL1:      w = s << 1;
      MODE_SHL2:      w = s << 2;
      MODE_SHL3:      w = s << 3;
      MODE_SHL5:      w = s << 5;
      MODE_SHL6:      w = s << 6;
      MODE_INVERT:    w = ~s;
      MODE_MASK_F000: w = s & 16'hF000;
      MODE_MASK_E7FF: w = s & 16'hE7FF;
      MODE_MASK_0087: w = s & 16'h0087;
      MODE_MASK_F7FF: w = s & 16'hF7FF;
      MODE_ZERO:      w = '0;
      default:        w = s;
    endcase
    return signed'(w);
  endfunction

endpackage

### hdl/bitcrush_multimode_mix_top.sv
// Top level of the multimode bit-crusher with dry/wet mix.
// Instantiates bcmm_coef_mac; types and constants from bcmm_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall) carries sample_in and block_start; a
//   transfer takes place when in_valid is high and in_stall low. One sample
//   is worked on at a time; in_stall is high while it is in progress.
//   Output channel (out_valid/out_stall) carries sample_out from a register.
//   Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
//   (0 mode, 1 amount); write only while no sample is in progress.
//   Path from input transfer to output valid:
//     bypass mode: straight to the done state and the output register;
//     mask, shift, invert and zero modes: through the serial amount multiply
//       and the bit-serial divide by 127;
//     low-pass mode: also through the two passes of the serial coefficient
//       MAC, one bit of the CW-bit coefficient per step (CW is 11 bits at
//       16 fractional bits).
//   The sequencer returns to idle after each output load and takes the next
//   sample from there. A finished sample waits in the output register while
//   out_stall is high; the next input is taken meanwhile and held at its final
//   step until the register frees up.
//   Reset clears mode, amount, the filter state and the output valid flag.
`timescale 1ns / 1ps

module bitcrush_multimode_mix_top
  import bcmm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [SAMPLE_W-1:0]   sample_in,
  input  logic                         block_start,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SAMPLE_W-1:0]   sample_out,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int DW = acc_width(FRAC_BITS);
  localparam logic signed [STATE_W:0] RND_ADD =
    (STATE_W+1)'((longint'(1) << FRAC_BITS) - 1);

  // Configuration registers
  mode_t                 mode;
  logic [AMOUNT_W-1:0]   amount;

  // Sequencer
  fsm_t state, state_next;
  logic [CNT_W-1:0] cnt;

  // Sample and filter state
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [STATE_W-1:0]  lp_band;
  logic signed [STATE_W-1:0]  lp_out;

  // Mix and divide datapath
  logic signed [MIX_W-1:0] mix_acc;
  logic signed [MIX_W-1:0] mul_sh;
  logic                    neg_r;
  logic [REM_W-1:0]        rem_r;
  logic [MAG_W-1:0]        div_sh;

  // Handshake and MAC control
  logic in_xfer;
  logic out_load;
  logic mac_start;
  logic mac_done;
  logic signed [STATE_W:0] mac_a;
  logic signed [STATE_W:0] mac_b;
  logic signed [DW-1:0]    mac_acc;

  // Combinational datapath
  logic signed [STATE_W:0]    lp_xs;
  logic signed [STATE_W-1:0]  upd_base;
  logic signed [DW:0]         upd_sum;
  logic [DW-STATE_W+1:0]      upd_hi;
  logic signed [STATE_W-1:0]  upd_sat;
  logic signed [STATE_W:0]    tz_sum;
  logic signed [STATE_W:0]    tz_val;
  logic [STATE_W-SAMPLE_W+1:0] tz_hi;
  logic signed [SAMPLE_W-1:0] lp_wet;
  logic signed [SAMPLE_W-1:0] wet;
  logic signed [MIX_W-1:0]    mul_term;
  logic signed [MIX_W-1:0]    mix_abs;
  logic [REM_W:0]             trial;
  logic                       trial_ge;
  logic [SAMPLE_W-1:0]        q16;
  logic signed [SAMPLE_W-1:0] y_val;

  bcmm_coef_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .rst   (rst),
    .start (mac_start),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .done  (mac_done),
    .acc   (mac_acc)
  );

  // Filter state update: add scaled MAC result, saturate to 40 bits
  always_comb begin
    lp_xs    = (STATE_W+1)'(x_r) <<< FRAC_BITS;
    upd_base = (state == ST_OUT) ? lp_out : lp_band;
    upd_sum  = (DW+1)'(upd_base) + (DW+1)'(mac_acc >>> FRAC_BITS);
    upd_hi   = upd_sum[DW:STATE_W-1];
    if ((&upd_hi) || (~|upd_hi)) begin
      upd_sat = upd_sum[STATE_W-1:0];
    end else begin
      upd_sat = {upd_sum[DW], {(STATE_W-1){~upd_sum[DW]}}};
    end
  end

  // Filter output truncated toward zero, saturated to 16 bits
  always_comb begin
    tz_sum = (STATE_W+1)'(lp_out) + (lp_out[STATE_W-1] ? RND_ADD : '0);
    tz_val = tz_sum >>> FRAC_BITS;
    tz_hi  = tz_val[STATE_W:SAMPLE_W-1];
    if ((&tz_hi) || (~|tz_hi)) begin
      lp_wet = tz_val[SAMPLE_W-1:0];
    end else begin
      lp_wet = {tz_val[STATE_W], {(SAMPLE_W-1){~tz_val[STATE_W]}}};
    end
    wet = (mode == MODE_LOWPASS) ? lp_wet : crush_wet(x_r, mode);
  end

  // Mix multiply term, magnitude, divider step and final result
  always_comb begin
    mul_term = amount[cnt[$clog2(AMOUNT_W)-1:0]] ? mul_sh : '0;
    mix_abs  = mix_acc[MIX_W-1] ? -mix_acc : mix_acc;
    trial    = {rem_r, div_sh[MAG_W-1]};
    trial_ge = (trial >= MIX_DIV);
    q16      = div_sh[SAMPLE_W-1:0];
    if (mode == MODE_BYPASS) begin
      y_val = x_r;
    end else begin
      y_val = neg_r ? signed'(16'(0 - q16)) : signed'(q16);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (mode == MODE_LOWPASS) begin
            state_next = ST_BAND_GO;
          end else if (mode == MODE_BYPASS) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_WET;
          end
        end
      end
      ST_BAND_GO: state_next = ST_BAND;
      ST_BAND:    if (mac_done) state_next = ST_OUT_GO;
      ST_OUT_GO:  state_next = ST_OUT;
      ST_OUT:     if (mac_done) state_next = ST_WET;
      ST_WET:     state_next = ST_MUL;
      ST_MUL:     if (cnt == CNT_W'(AMOUNT_W - 1)) state_next = ST_ABS;
      ST_ABS:     state_next = ST_DIV;
      ST_DIV:     if (cnt == CNT_W'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE:    if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // State-driven outputs
  always_comb begin
    in_stall  = 1'b1;
    mac_start = 1'b0;
    mac_a     = lp_xs - (STATE_W+1)'(lp_out);
    mac_b     = (STATE_W+1)'(lp_band);
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:    in_stall = 1'b0;
      ST_BAND_GO: mac_start = 1'b1;
      ST_OUT_GO: begin
        mac_start = 1'b1;
        mac_a     = (STATE_W+1)'(lp_band);
        mac_b     = (STATE_W+1)'(lp_out);
      end
      ST_DONE:    out_load = !out_valid || !out_stall;
      default:    ;
    endcase
  end

  assign in_xfer = in_valid && !in_stall;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_BYPASS;
      amount <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:   mode   <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_AMOUNT: amount <= cfg_wdata[AMOUNT_W-1:0];
        default:    ;
      endcase
    end
  end

  // Filter state: cleared at block start, updated after each MAC pass
  always_ff @(posedge clk) begin
    if (rst) begin
      lp_band <= '0;
      lp_out  <= '0;
    end else if (in_xfer && block_start) begin
      lp_band <= '0;
      lp_out  <= '0;
    end else if (mac_done && (state == ST_BAND)) begin
      lp_band <= upd_sat;
    end else if (mac_done && (state == ST_OUT)) begin
      lp_out <= upd_sat;
    end
  end

  // Sample capture, serial mix multiply and bit-serial divide by 127
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      x_r <= sample_in;
    end
    unique case (state)
      ST_WET: begin
        mix_acc <= (MIX_W'(x_r) <<< AMOUNT_W) - MIX_W'(x_r);
        mul_sh  <= MIX_W'(wet) - MIX_W'(x_r);
        cnt     <= '0;
      end
      ST_MUL: begin
        mix_acc <= mix_acc + mul_term;
        mul_sh  <= mul_sh <<< 1;
        cnt     <= cnt + 1'b1;
      end
      ST_ABS: begin
        neg_r  <= mix_acc[MIX_W-1];
        div_sh <= mix_abs[MAG_W-1:0];
        rem_r  <= '0;
        cnt    <= '0;
      end
      ST_DIV: begin
        rem_r  <= trial_ge ? REM_W'(trial - MIX_DIV) : trial[REM_W-1:0];
        div_sh <= {div_sh[MAG_W-2:0], trial_ge};
        cnt    <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sample_out <= y_val;
    end
  end

endmodule

### hdl/bcmm_coef_mac.sv
// Serial constant-coefficient multiply-accumulate for the low-pass filter.
// Computes c*op_a - rc*op_b one coefficient bit per cycle; uses bcmm_pkg.
`timescale 1ns / 1ps

module bcmm_coef_mac
  import bcmm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic signed [STATE_W:0]                 op_a,
  input  logic signed [STATE_W:0]                 op_b,
  output logic                                    done,
  output logic signed [acc_width(FRAC_BITS)-1:0]  acc
);

  localparam longint C_VAL  = coef_c(FRAC_BITS);
  localparam longint RC_VAL = coef_rc(FRAC_BITS);
  localparam int     CW     = $clog2(C_VAL + 1);
  localparam int     KW     = $clog2(CW);
  localparam int     DW     = acc_width(FRAC_BITS);
  localparam logic [CW-1:0] C_VEC  = CW'(C_VAL);
  localparam logic [CW-1:0] RC_VEC = CW'(RC_VAL);
  localparam logic [KW-1:0] K_LAST = KW'(CW - 1);

  logic                 busy;
  logic [KW-1:0]        k;
  logic signed [DW-1:0] a_sh;
  logic signed [DW-1:0] b_sh;
  logic signed [DW-1:0] a_term;
  logic signed [DW-1:0] b_term;

  // Partial products selected by the current coefficient bit
  always_comb begin
    a_term = C_VEC[k]  ? a_sh : '0;
    b_term = RC_VEC[k] ? b_sh : '0;
  end

  // Control: bit counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        k    <= '0;
      end else if (busy) begin
        k <= k + 1'b1;
        if (k == K_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: multiplicands shift left, accumulator adds selected terms
  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= DW'(op_a);
      b_sh <= DW'(op_b);
      acc  <= '0;
    end else if (busy) begin
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh <<< 1;
      acc  <= acc + a_term - b_term;
    end
  end

endmodule
